// ===== rtl/byte_ring_fifo_core_defines.svh =====
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Shared concurrent assertion forms used by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_CORE_DEFINES_SVH
`define BYTE_RING_FIFO_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never be true.
`define BRF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Sizes, command codes and the request types shared by the front and back.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int PEEK_MAX    = 64;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CAP_W   = 8;
  localparam int CMP_W   = CAP_W + 1;
  localparam int DATA_W  = 8;
  localparam int ASK_W   = 7;
  localparam int REM_W   = $clog2(PEEK_MAX + 1);

  // Request queue between front and back; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] data;
    logic [REM_W-1:0]  ask;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

  typedef enum logic {
    ST_EXEC,
    ST_PEEK
  } back_state_e;

endpackage

// ===== rtl/brf_front.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO front
// Accepts requests, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_core_defines.svh"

module brf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [brf_pkg::DATA_W-1:0]   data_in_i,
  input  logic [brf_pkg::ASK_W-1:0]    peek_count_i,
  input  logic                         pop_i,
  output brf_pkg::head_t               head_o
);
  import brf_pkg::*;

  req_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;
  req_t              req_in;

  // Only the fields a command uses are kept; the peek length is clamped here
  // since the clamp does not depend on the FIFO state.
  always_comb begin
    req_in.cmd  = cmd_e'(command_i);
    req_in.data = (req_in.cmd == CMD_APPEND) ? data_in_i : '0;
    req_in.ask  = '0;
    if (req_in.cmd == CMD_PEEK) begin
      if (peek_count_i > ASK_W'(PEEK_MAX)) begin
        req_in.ask = REM_W'(PEEK_MAX);
      end else begin
        req_in.ask = peek_count_i[REM_W-1:0];
      end
    end
  end

  assign in_stall_o = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= req_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.req   = slots_q[rd_ptr_q];

  `BRF_ASSERT_IMPLIES(a_pop_nonempty, clk_i, rst_ni, pop_i, count_q != '0,
                      "front popped while the queue was empty")
  `BRF_ASSERT_NEVER(a_count_bound, clk_i, rst_ni,
                    count_q > (QPTR_W + 1)'(QUEUE_DEPTH),
                    "front queue count above its depth")
  `BRF_ASSERT_NEXT(a_push_counts, clk_i, rst_ni, push && !pop, count_q != '0,
                   "front queue empty after a push")

endmodule

// ===== rtl/brf_back.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO back
// Executes queued requests against the ring store and registers the results.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_core_defines.svh"

module brf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brf_pkg::head_t              head_i,
  output logic                        pop_o,
  input  logic                        cfg_we_i,
  input  logic [brf_pkg::CAP_W-1:0]   cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [brf_pkg::DATA_W-1:0]  data_out_o,
  output logic                        ok_o,
  output logic [brf_pkg::CAP_W-1:0]   fill_level_o,
  output logic [brf_pkg::CAP_W-1:0]   free_space_o,
  output logic                        last_o
);
  import brf_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CAP_W-1:0]  held_q, held_d;
  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] run_ptr_q, run_ptr_d;
  logic [REM_W-1:0]  run_rem_q, run_rem_d;

  logic              out_valid_q;
  logic              out_sel_q, out_ok_q, out_last_q;
  logic [CAP_W-1:0]  out_fill_q, out_free_q;
  logic [DATA_W-1:0] rdata_q;

  logic [CMP_W-1:0]  eff_cap;
  logic              slot_free, adv;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              res_sel, res_ok, res_last;
  logic [CAP_W-1:0]  res_free;
  logic [CAP_W-1:0]  ask_ext, clamp8;
  logic [REM_W-1:0]  clamp_n;

  function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p,
                                                 input logic [CMP_W-1:0]  cap);
    logic [CMP_W-1:0] n;
    n = {{(CMP_W - ADDR_W){1'b0}}, p} + CMP_W'(1);
    return (n >= cap) ? '0 : n[ADDR_W-1:0];
  endfunction

  assign eff_cap = (CMP_W'(cap_q) > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH)
                                                         : CMP_W'(cap_q);

  assign slot_free = !out_valid_q || !out_stall_i;
  assign adv       = slot_free && ((state_q == ST_PEEK) || head_i.valid);

  // Peek length: the front already bounded it by the run limit.
  assign ask_ext = CAP_W'(head_i.req.ask);
  assign clamp8  = (ask_ext < held_q) ? ask_ext : held_q;
  assign clamp_n = clamp8[REM_W-1:0];

  always_comb begin
    state_d   = state_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    held_d    = held_q;
    run_ptr_d = run_ptr_q;
    run_rem_d = run_rem_q;
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = rd_ptr_q;
    res_sel   = 1'b0;
    res_ok    = 1'b0;
    res_last  = 1'b1;

    unique case (state_q)
      ST_EXEC: begin
        if (adv) begin
          pop_o = 1'b1;
          unique case (head_i.req.cmd)
            CMD_APPEND: begin
              if (CMP_W'(held_q) < eff_cap) begin
                wr_en    = 1'b1;
                wr_ptr_d = next_ptr(wr_ptr_q, eff_cap);
                held_d   = held_q + 1'b1;
                res_ok   = 1'b1;
              end
            end
            CMD_TAKE: begin
              if (held_q != '0) begin
                rd_en    = 1'b1;
                res_sel  = 1'b1;
                res_ok   = 1'b1;
                held_d   = held_q - 1'b1;
                rd_ptr_d = next_ptr(rd_ptr_q, eff_cap);
              end
            end
            CMD_PEEK: begin
              if (clamp_n != '0) begin
                rd_en    = 1'b1;
                res_sel  = 1'b1;
                res_ok   = 1'b1;
                res_last = (clamp_n == REM_W'(1));
                if (clamp_n != REM_W'(1)) begin
                  state_d   = ST_PEEK;
                  run_ptr_d = next_ptr(rd_ptr_q, eff_cap);
                  run_rem_d = clamp_n - 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              held_d   = '0;
              res_ok   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PEEK: begin
        if (adv) begin
          rd_en     = 1'b1;
          rd_addr   = run_ptr_q;
          res_sel   = 1'b1;
          res_ok    = 1'b1;
          res_last  = (run_rem_q == REM_W'(1));
          run_ptr_d = next_ptr(run_ptr_q, eff_cap);
          run_rem_d = run_rem_q - 1'b1;
          if (run_rem_q == REM_W'(1)) begin
            state_d = ST_EXEC;
          end
        end
      end
      default: begin
        state_d = ST_EXEC;
      end
    endcase

    // A capacity write empties the ring; it must arrive only while idle, which the block does not enforce.
    if (cfg_we_i) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      held_d   = '0;
    end
  end

  assign res_free = CAP_W'(eff_cap - CMP_W'(held_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      held_q      <= '0;
      state_q     <= ST_EXEC;
      run_rem_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      held_q    <= held_d;
      state_q   <= state_d;
      run_rem_q <= run_rem_d;
      if (slot_free) begin
        out_valid_q <= adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_ptr_q <= run_ptr_d;
    if (adv) begin
      out_sel_q  <= res_sel;
      out_ok_q   <= res_ok;
      out_last_q <= res_last;
      out_fill_q <= held_d;
      out_free_q <= res_free;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr_q] <= head_i.req.data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_sel_q ? rdata_q : '0;
  assign ok_o         = out_ok_q;
  assign fill_level_o = out_fill_q;
  assign free_space_o = out_free_q;
  assign last_o       = out_last_q;

  `BRF_ASSERT_NEVER(a_held_bound, clk_i, rst_ni, CMP_W'(held_q) > eff_cap,
                    "held count above the capacity")
  `BRF_ASSERT_NEVER(a_ptr_range, clk_i, rst_ni,
                    (eff_cap != '0) &&
                    ((CMP_W'(rd_ptr_q) >= eff_cap) || (CMP_W'(wr_ptr_q) >= eff_cap)),
                    "ring pointer outside the capacity")
  `BRF_ASSERT_IMPLIES(a_run_nonzero, clk_i, rst_ni, state_q == ST_PEEK,
                      (run_rem_q != '0) && (held_q != '0),
                      "peek run active with nothing left to give")

endmodule

// ===== rtl/byte_ring_fifo_core.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO core
// Byte FIFO in a ring of programmable capacity with append, take, peek, clear.
// ----------------------------------------------------------------------------
// Each request carries one command: append a byte, take the oldest byte,
// peek a run of the oldest bytes without removing them, or clear. Append,
// take and clear produce one result each, with last set; a peek produces
// min(peek_count, fill level, 64) results in order from the oldest byte,
// last set on the final one, or a single result with ok clear when that
// count is zero. Every result carries the fill level and free space after
// the step. While the output is not stalled, the sustained rate is one
// request per cycle for append, take and clear, and a peek gives one
// result per cycle; the rate is set by the back-end sequencer, which issues
// one access per cycle to the single-write, single-read byte store and
// walks a peek run one entry at a time. An accepted request is written
// into the two-entry request queue, and the back end then executes it
// and loads the result register together with the registered store read.
// The request queue lets new requests be accepted while a result waits to
// be taken. The capacity register (reset 255) may be any value from 0 to
// 255 and need not be a power of two; writing it empties the FIFO but keeps
// the stored bytes, and it must only be written while the block is idle.
// No clearing pass runs after reset, since a slot is never read before it
// has been written.

module byte_ring_fifo_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic [brf_pkg::DATA_W-1:0]  data_in_i,
  input  logic [brf_pkg::ASK_W-1:0]   peek_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [brf_pkg::DATA_W-1:0]  data_out_o,
  output logic                        ok_o,
  output logic [brf_pkg::CAP_W-1:0]   fill_level_o,
  output logic [brf_pkg::CAP_W-1:0]   free_space_o,
  output logic                        last_o,
  input  logic                        cfg_we_i,
  input  logic [brf_pkg::CAP_W-1:0]   cfg_wdata_i
);
  import brf_pkg::*;

  // Oldest queued request and its valid flag, handed from front to back.
  head_t head;
  // Back end consumes the head request when it starts executing it.
  logic  pop;

  // Front end: request handshake, command decode and the request queue.
  brf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .data_in_i    (data_in_i),
    .peek_count_i (peek_count_i),
    .pop_i        (pop),
    .head_o       (head)
  );

  // Back end: ring pointers, byte store, peek sequencer and result register.
  brf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .ok_o         (ok_o),
    .fill_level_o (fill_level_o),
    .free_space_o (free_space_o),
    .last_o       (last_o)
  );

endmodule
